/* src/matrix_vector_product_unit_macros.svh */
// Assertion macros shared by the matrix-vector product unit modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef MATRIX_VECTOR_PRODUCT_UNIT_MACROS_SVH
`define MATRIX_VECTOR_PRODUCT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mvp_pkg.sv */
// Shared constants and types for the matrix-vector product unit.
// No dependencies.
package mvp_pkg;

   localparam int MAX_ORDER   = 16;
   localparam int IDX_W       = $clog2(MAX_ORDER);
   localparam int CNT_W       = $clog2(MAX_ORDER + 1);
   localparam int CFG_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int ROW_W       = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic MODE_VECTOR = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

   // One matrix element, classified by the front end.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [VALUE_W-1:0]        coef;
      logic                      first;
      logic                      end_of_row;
      logic [ROW_W-1:0]          row;
      logic                      last;
   } op_type;

endpackage

/* src/mvp_ifs.sv */
// Valid/ready channel interfaces for the request and response beats.
// Depends on mvp_pkg.
interface mvp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [mvp_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface mvp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mvp_pkg::VALUE_W-1:0] product;
   logic [mvp_pkg::ROW_W-1:0]          row_index;
   logic                               last_of_run;

   modport source (output valid, output product, output row_index, output last_of_run,
                   input ready);
   modport sink (input valid, input product, input row_index, input last_of_run,
                 output ready);
endinterface

/* src/mvp_front.sv */
// Front end: order register, vector store, row/column counters; tags matrix beats.
// Depends on mvp_pkg, mvp_ifs and the assertion macros.
`include "matrix_vector_product_unit_macros.svh"

module mvp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mvp_pkg::CFG_W-1:0] csr_wr_data,
   mvp_req_if.sink                   req,
   input  logic                      queue_full,
   output logic                      push_valid,
   output mvp_pkg::op_type           push_op
);
   import mvp_pkg::*;

   logic [CFG_W-1:0]   size_ff;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [VALUE_W-1:0] store_ff [MAX_ORDER];

   logic [CNT_W-1:0] order;
   logic [CNT_W-1:0] slot;
   logic             accept;
   logic             end_of_row;
   logic             last_row;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Zero behaves as one, oversize saturates.
   always_comb begin
      if (size_ff == '0) begin
         order = CNT_W'(1);
      end else if (int'(size_ff) > MAX_ORDER) begin
         order = CNT_W'(MAX_ORDER);
      end else begin
         order = CNT_W'(size_ff);
      end
   end

   assign slot       = (fill_ff >= order) ? '0 : fill_ff;
   assign end_of_row = (CNT_W'(col_ff) + CNT_W'(1)) >= order;
   assign last_row   = (CNT_W'(row_ff) + CNT_W'(1)) >= order;

   always_comb begin
      fill_in = fill_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         case (req.mode)
            MODE_VECTOR: begin
               fill_in = slot + CNT_W'(1);
               col_in  = '0;
               row_in  = '0;
            end
            MODE_MATRIX: begin
               if (end_of_row) begin
                  col_in = '0;
                  row_in = last_row ? '0 : row_ff + IDX_W'(1);
               end else begin
                  col_in = col_ff + IDX_W'(1);
               end
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   assign push_valid         = accept && (req.mode == MODE_MATRIX);
   assign push_op.value      = req.value;
   assign push_op.coef       = store_ff[col_ff];
   assign push_op.first      = (col_ff == '0);
   assign push_op.end_of_row = end_of_row;
   assign push_op.row        = ROW_W'(row_ff);
   assign push_op.last       = last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         fill_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         fill_ff <= fill_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req.mode == MODE_VECTOR)) begin
         store_ff[slot[IDX_W-1:0]] <= req.value;
      end
   end

   `MVP_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, int'(fill_ff) <= MAX_ORDER,
      "vector fill count beyond store depth")
   `MVP_ASSERT_NEXT(a_vector_restarts, clock, reset,
      accept && (req.mode == MODE_VECTOR), (col_ff == '0) && (row_ff == '0),
      "vector beat did not restart the counters")
   `MVP_ASSERT_NOW(a_push_needs_room, clock, reset, push_valid, !queue_full,
      "push into a full queue")

endmodule

/* src/mvp_queue.sv */
// Small FIFO between front end and multiply-accumulate back end.
// Depends on mvp_pkg and the assertion macros.
`include "matrix_vector_product_unit_macros.svh"

module mvp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  mvp_pkg::op_type push_op,
   output logic            full,
   output logic            pop_valid,
   output mvp_pkg::op_type pop_op,
   input  logic            pop
);
   import mvp_pkg::*;

   op_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (int'(count_ff) == QUEUE_DEPTH);
   assign pop_valid = (count_ff != '0);
   assign pop_op    = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_op;
      end
   end

   `MVP_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, int'(count_ff) <= QUEUE_DEPTH,
      "queue count overflow")
   `MVP_ASSERT_NOW(a_ptr_gap, clock, reset, 1'b1,
      QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0],
      "queue pointers disagree with count")
   `MVP_ASSERT_NEXT(a_pop_drains, clock, reset, do_pop && !do_push && (count_ff == (QPTR_W+1)'(1)),
      !pop_valid, "last entry popped but queue still shows data")

endmodule

/* src/mvp_back.sv */
// Back end: registered multiply, accumulate, and a result output register.
// Depends on mvp_pkg, mvp_ifs and the assertion macros.
`include "matrix_vector_product_unit_macros.svh"

module mvp_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  mvp_pkg::op_type pop_op,
   output logic            pop,
   mvp_rsp_if.source       rsp
);
   import mvp_pkg::*;

   logic               mul_v_ff;
   logic [VALUE_W-1:0] prod_ff, prod_in;
   logic               first_ff, eor_ff, last_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [VALUE_W-1:0] acc_ff, sum;
   logic               out_v_ff;
   logic [VALUE_W-1:0] out_sum_ff;
   logic [ROW_W-1:0]   out_row_ff;
   logic               out_last_ff;
   logic               mul_adv, mul_load;

   // A row end may only leave the multiply stage when the output slot frees up.
   assign mul_adv  = mul_v_ff && (!eor_ff || !out_v_ff || rsp.ready);
   assign mul_load = pop_valid && (!mul_v_ff || mul_adv);
   assign pop      = mul_load;

   // Wrap to 32 bits; low product bits do not depend on signedness.
   assign prod_in = VALUE_W'(pop_op.value * pop_op.coef);
   assign sum     = (first_ff ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (mul_load) begin
            mul_v_ff <= 1'b1;
         end else if (mul_adv) begin
            mul_v_ff <= 1'b0;
         end
         if (mul_adv && eor_ff) begin
            out_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff  <= prod_in;
         first_ff <= pop_op.first;
         eor_ff   <= pop_op.end_of_row;
         row_ff   <= pop_op.row;
         last_ff  <= pop_op.last;
      end
      if (mul_adv) begin
         acc_ff <= sum;
         if (eor_ff) begin
            out_sum_ff  <= sum;
            out_row_ff  <= row_ff;
            out_last_ff <= last_ff;
         end
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.product     = out_sum_ff;
   assign rsp.row_index   = out_row_ff;
   assign rsp.last_of_run = out_last_ff;

   `MVP_ASSERT_NEXT(a_row_end_held, clock, reset,
      mul_v_ff && eor_ff && out_v_ff && !rsp.ready, mul_v_ff && eor_ff,
      "row end dropped while result stalled")
   `MVP_ASSERT_NOW(a_empty_stage_loads, clock, reset, pop_valid && !mul_v_ff, pop,
      "idle multiply stage did not take a queued beat")
   `MVP_ASSERT_NOW(a_no_overwrite, clock, reset, out_v_ff && !rsp.ready, !(mul_adv && eor_ff),
      "pending result overwritten")

endmodule

/* src/matrix_vector_product_unit.sv */
// Matrix-vector product unit, streamed: vector beats load the store, matrix beats accumulate.
// A row's last matrix beat passes the queue, the multiply register and the output register to rsp_bus.
// Throughput: one request beat per cycle while the queue is not full; the single multiply stage sets the rate.
// A 4-entry queue decouples intake from the multiply-accumulate pipeline.
// Reset (synchronous) clears counters, queue and pipeline, sets the order to 16;
// vector store contents stay undefined until written.
module matrix_vector_product_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mvp_pkg::CFG_W-1:0] csr_wr_data,
   mvp_req_if.sink                   req_bus,
   mvp_rsp_if.source                 rsp_bus
);
   import mvp_pkg::*;

   logic   push_valid, queue_full, pop_valid, pop;
   op_type push_op, pop_op;

   mvp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_op     (push_op)
   );

   mvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_op   (push_op),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop       (pop)
   );

   mvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
